>>> hw/rtl/hkm_pkg.sv
// Package with the shared types, constants and codes of the heap k-way merger.
package hkm_pkg;

  // Default sizes of the heap and of the stored keys.
  localparam int unsigned MAX_LISTS = 16;
  localparam int unsigned KEY_BITS  = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned LIST_BITS   = 4;
  localparam int unsigned STATUS_BITS = 2;

  // Request operation codes.
  localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_EXHAUST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_MIN      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FINISHED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_REJECT   = 2'd2;

  // One request.
  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic signed [VALUE_BITS-1:0] key_value;
    logic [LIST_BITS-1:0]         list_id;
    logic                         present;
    logic                         last;
  } req_t;

  // One result.
  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic signed [VALUE_BITS-1:0] min_value;
    logic [LIST_BITS-1:0]         min_list;
  } res_t;

  // Source of the first memory read address.
  typedef enum logic [1:0] {
    RD_POS   = 2'd0,
    RD_LAST  = 2'd1,
    RD_CHILD = 2'd2,
    RD_ROOT  = 2'd3
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    insert;
    rd_sel_e rd_sel;
    logic    mv_load;
    logic    mv_key_in;
    logic    count_dec;
    logic    pos_root;
    logic    build_init;
    logic    build_next;
    logic    descend;
    logic    place;
    logic    emit_min;
    logic    emit_fin;
    logic    emit_rej;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic count_zero;
    logic count_one;
    logic half_zero;
    logic has_child;
    logic stop;
    logic p_gt1;
  } dp_stat_t;

endpackage

>>> hw/rtl/hkm_dp.sv
// Datapath of the heap k-way merger: heap memory, count, positions and result register.
module hkm_dp #(
  parameter int unsigned MaxLists = hkm_pkg::MAX_LISTS,
  parameter int unsigned KeyBits  = hkm_pkg::KEY_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hkm_pkg::req_t     req_i,
  input  hkm_pkg::ctrl_cmd_t cmd_i,
  output hkm_pkg::dp_stat_t stat_o,
  output hkm_pkg::res_t     res_o,
  output logic              res_valid_o
);

  localparam int unsigned NW = $clog2(MaxLists + 1);
  localparam int unsigned IW = $clog2(2 * MaxLists + 2);
  localparam int unsigned AW = $clog2(MaxLists);
  localparam int unsigned LB = hkm_pkg::LIST_BITS;
  localparam int unsigned VB = hkm_pkg::VALUE_BITS;

  // Heap storage; position p lives at address p - 1.
  logic [KeyBits-1:0] key_mem  [MaxLists];
  logic [LB-1:0]      list_mem [MaxLists];

  logic [NW-1:0]      count_q, count_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [NW-1:0]      p_q, p_d;
  logic [KeyBits-1:0] key_q;
  logic [KeyBits-1:0] mv_key_q;
  logic [LB-1:0]      mv_list_q;
  logic [KeyBits-1:0] rd_a_key_q, rd_b_key_q;
  logic [LB-1:0]      rd_a_list_q, rd_b_list_q;
  logic [KeyBits-1:0] key_ext;
  logic [VB-1:0]      min_out;
  hkm_pkg::res_t      res_q;
  logic               res_valid_q;

  logic [IW-1:0]      child;
  logic [IW-1:0]      child_r;
  logic [AW-1:0]      addr_a, addr_b;
  logic               take_b;
  logic [KeyBits-1:0] ch_key;
  logic [LB-1:0]      ch_list;
  logic [IW-1:0]      ch_idx;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [KeyBits-1:0] wr_key;
  logic [LB-1:0]      wr_list;

  // Key narrowing or widening of the incoming value, and the 32-bit view of a stored key.
  if (KeyBits <= VB) begin : g_narrow
    assign key_ext = req_i.key_value[KeyBits-1:0];
    assign min_out = VB'(rd_a_key_q);
  end else begin : g_wide
    assign key_ext = {{(KeyBits - VB){1'b0}}, req_i.key_value};
    assign min_out = rd_a_key_q[VB-1:0];
  end

  // Child positions of the current position.
  assign child   = pos_q << 1;
  assign child_r = child + IW'(1);

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      hkm_pkg::RD_LAST:  addr_a = AW'(count_q - NW'(1));
      hkm_pkg::RD_CHILD: addr_a = AW'(child - IW'(1));
      hkm_pkg::RD_ROOT:  addr_a = '0;
      default:           addr_a = AW'(pos_q - IW'(1));
    endcase
    addr_b = AW'(child);
  end

  // Smaller child; the right one wins only if it is strictly smaller.
  assign take_b  = (child_r <= IW'(count_q)) &&
                   ($signed(rd_b_key_q) < $signed(rd_a_key_q));
  assign ch_key  = take_b ? rd_b_key_q : rd_a_key_q;
  assign ch_list = take_b ? rd_b_list_q : rd_a_list_q;
  assign ch_idx  = take_b ? child_r : child;

  // Status toward the controller.
  assign stat_o.full       = (count_q == NW'(MaxLists));
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_one  = (count_q == NW'(1));
  assign stat_o.half_zero  = ((count_q >> 1) == '0);
  assign stat_o.has_child  = (child <= IW'(count_q));
  assign stat_o.stop       = ($signed(ch_key) >= $signed(mv_key_q));
  assign stat_o.p_gt1      = (p_q > NW'(1));

  // Write port selection.
  always_comb begin
    wr_en   = cmd_i.insert | cmd_i.descend | cmd_i.place;
    wr_addr = AW'(pos_q - IW'(1));
    wr_key  = mv_key_q;
    wr_list = mv_list_q;
    if (cmd_i.insert) begin
      wr_addr = AW'(count_q);
      wr_key  = key_ext;
      wr_list = req_i.list_id;
    end else if (cmd_i.descend) begin
      wr_key  = ch_key;
      wr_list = ch_list;
    end
  end

  // Heap memory with one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      list_mem[wr_addr] <= wr_list;
    end
    rd_a_key_q  <= key_mem[addr_a];
    rd_a_list_q <= list_mem[addr_a];
    rd_b_key_q  <= key_mem[addr_b];
    rd_b_list_q <= list_mem[addr_b];
  end

  // Next values of count and positions.
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    p_d     = p_q;
    if (cmd_i.insert) begin
      count_d = count_q + NW'(1);
    end else if (cmd_i.count_dec) begin
      count_d = count_q - NW'(1);
    end
    if (cmd_i.pos_root) begin
      pos_d = IW'(1);
    end else if (cmd_i.build_init) begin
      pos_d = IW'(count_q >> 1);
      p_d   = count_q >> 1;
    end else if (cmd_i.build_next) begin
      pos_d = IW'(p_q - NW'(1));
      p_d   = p_q - NW'(1);
    end else if (cmd_i.descend) begin
      pos_d = ch_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Position registers, input key and moving entry.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    p_q   <= p_d;
    if (cmd_i.latch_in) begin
      key_q <= key_ext;
    end
    if (cmd_i.mv_load) begin
      mv_key_q  <= cmd_i.mv_key_in ? key_q : rd_a_key_q;
      mv_list_q <= rd_a_list_q;
    end
  end

  // Result register and its strobe.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_min) begin
      res_q.status    <= hkm_pkg::ST_MIN;
      res_q.min_value <= min_out;
      res_q.min_list  <= rd_a_list_q;
    end else if (cmd_i.emit_fin) begin
      res_q.status    <= hkm_pkg::ST_FINISHED;
      res_q.min_value <= '0;
      res_q.min_list  <= '0;
    end else if (cmd_i.emit_rej) begin
      res_q.status    <= hkm_pkg::ST_REJECT;
      res_q.min_value <= '0;
      res_q.min_list  <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_min | cmd_i.emit_fin | cmd_i.emit_rej;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

>>> hw/rtl/hkm_ctrl.sv
// Controller state machine of the heap k-way merger: phase tracking and sift sequencing.
module hkm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [hkm_pkg::OP_BITS-1:0] op_i,
  input  logic               present_i,
  input  logic               last_i,
  input  hkm_pkg::dp_stat_t  stat_i,
  output hkm_pkg::ctrl_cmd_t cmd_o,
  output logic               busy
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_BUILD   = 9'b000000010,
    S_FETCH   = 9'b000000100,
    S_LATCH   = 9'b000001000,
    S_SD_RD   = 9'b000010000,
    S_SD_CMP  = 9'b000100000,
    S_PLACE   = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   merging_q, merging_d;
  logic   build_q, build_d;
  logic   adv_q, adv_d;

  // Next state and commands.
  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    merging_d = merging_q;
    build_d   = build_q;
    adv_d     = adv_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          if (op_i == hkm_pkg::OP_LOAD && !merging_q) begin
            if (present_i && stat_i.full) begin
              cmd_o.emit_rej = 1'b1;
            end else begin
              cmd_o.insert = present_i;
              if (last_i) begin
                build_d = 1'b1;
                adv_d   = 1'b0;
                state_d = S_BUILD;
              end
            end
          end else if (merging_q &&
                       (op_i == hkm_pkg::OP_ADVANCE || op_i == hkm_pkg::OP_EXHAUST)) begin
            cmd_o.pos_root = 1'b1;
            adv_d          = (op_i == hkm_pkg::OP_ADVANCE);
            build_d        = 1'b0;
            state_d        = S_FETCH;
          end else begin
            cmd_o.emit_rej = 1'b1;
          end
        end
      end
      // Start of the bottom-up heap build.
      S_BUILD: begin
        if (stat_i.count_zero) begin
          cmd_o.emit_fin = 1'b1;
          build_d        = 1'b0;
          state_d        = S_IDLE;
        end else if (stat_i.half_zero) begin
          merging_d = 1'b1;
          state_d   = S_EMIT_RD;
        end else begin
          cmd_o.build_init = 1'b1;
          merging_d        = 1'b1;
          state_d          = S_FETCH;
        end
      end
      // Read the entry that is about to move down.
      S_FETCH: begin
        cmd_o.rd_sel = (build_q || adv_q) ? hkm_pkg::RD_POS : hkm_pkg::RD_LAST;
        state_d      = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.mv_load   = 1'b1;
        cmd_o.mv_key_in = adv_q && !build_q;
        if (!build_q && !adv_q) begin
          cmd_o.count_dec = 1'b1;
          if (stat_i.count_one) begin
            cmd_o.emit_fin = 1'b1;
            merging_d      = 1'b0;
            state_d        = S_IDLE;
          end else begin
            state_d = S_SD_RD;
          end
        end else begin
          state_d = S_SD_RD;
        end
      end
      // One level of the sift-down: read both children, then compare and move.
      S_SD_RD: begin
        cmd_o.rd_sel = hkm_pkg::RD_CHILD;
        state_d      = stat_i.has_child ? S_SD_CMP : S_PLACE;
      end
      S_SD_CMP: begin
        if (stat_i.stop) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.descend = 1'b1;
          state_d       = S_SD_RD;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        if (build_q && stat_i.p_gt1) begin
          cmd_o.build_next = 1'b1;
          state_d          = S_FETCH;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_sel = hkm_pkg::RD_ROOT;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_min = 1'b1;
        build_d        = 1'b0;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      merging_q <= 1'b0;
      build_q   <= 1'b0;
      adv_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      merging_q <= merging_d;
      build_q   <= build_d;
      adv_q     <= adv_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> hw/rtl/heap_kway_merger.sv
// Top level of the heap k-way merger: controller and datapath.
//
//   channel   direction  handshake               payload
//   request   in         start high, busy low    req_i (op, key_value, list_id, present, last)
//   result    out        res_valid_o, one cycle  res_o (status, min_value, min_list)
//
// A rejected request or a load without last is handled in idle and leaves busy low; a rejection
// shows its result in the next cycle. Advance and exhausted keep busy high through the fetch and
// latch of the moving entry, a child read and a compare for each of the d levels it descends
// (at most log2 of the heap size), one more child read, a compare when it stops above a child,
// the place, and the root read and emit; when the last entry leaves, only fetch and latch run.
// A final load runs one such sift for each of the count/2 inner positions before the minimum is
// shown. Reset clears the phase and the entry count; the heap memory needs no clearing.
// The receiver cannot stall: res_valid_o is high for exactly one cycle per result.
module heap_kway_merger #(
  parameter int unsigned MaxLists = hkm_pkg::MAX_LISTS,
  parameter int unsigned KeyBits  = hkm_pkg::KEY_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hkm_pkg::req_t req_i,
  output hkm_pkg::res_t res_o,
  output logic          res_valid_o
);

  hkm_pkg::ctrl_cmd_t cmd;
  hkm_pkg::dp_stat_t  stat;

  // Sequencing of each request.
  hkm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .op_i      (req_i.op),
    .present_i (req_i.present),
    .last_i    (req_i.last),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Heap storage and arithmetic.
  hkm_dp #(
    .MaxLists (MaxLists),
    .KeyBits  (KeyBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
